// File: src/gcl_pkg.sv
package gcl_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV,
    ST_MUL,
    ST_OUT
  } state_e;

  // sequencer to datapath
  typedef struct packed {
    state_e phase;
    logic   load;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic op_zero;
    logic gcd_done;
  } status_t;

endpackage

// File: src/gcl_dp.sv
module gcl_dp #(
  parameter int W = 32
) (
  input  logic              clk_i,
  input  logic [31:0]       operand_a_i,
  input  logic [31:0]       operand_b_i,
  input  gcl_pkg::ctrl_t    ctrl_i,
  output gcl_pkg::status_t  status_o,
  output logic [W-1:0]      gcd_o,
  output logic [2*W-1:0]    prod_o,
  output logic              err_o
);

  localparam int KW = $clog2(W);

  logic [W-1:0]  a_m, b_m;
  logic [W-1:0]  x_q, x_d, y_q, y_d;
  logic [KW-1:0] k_q, k_d;
  logic [W-1:0]  q_q, q_d, b_q, b_d, r_q, r_d, hi_q, hi_d;
  logic          err_q, err_d;

  // shared adder
  logic [W:0]    add_p, add_q, add_s;
  logic          add_c;
  logic [W:0]    part;

  assign a_m = operand_a_i[W-1:0];
  assign b_m = operand_b_i[W-1:0];

  assign part  = {r_q, q_q[W-1]};
  assign add_s = add_p + add_q + {{W{1'b0}}, add_c};

  always_comb begin
    add_p = '0;
    add_q = '0;
    add_c = 1'b0;
    case (ctrl_i.phase)
      gcl_pkg::ST_GCD: begin
        add_p = {1'b0, y_q};
        add_q = ~{1'b0, x_q};
        add_c = 1'b1;
      end
      gcl_pkg::ST_DIV: begin
        add_p = part;
        add_q = ~{1'b0, x_q};
        add_c = 1'b1;
      end
      gcl_pkg::ST_MUL: begin
        add_p = {1'b0, hi_q};
        add_q = q_q[0] ? {1'b0, b_q} : '0;
        add_c = 1'b0;
      end
      default: begin
        add_p = '0;
      end
    endcase
  end

  always_comb begin
    x_d   = x_q;
    y_d   = y_q;
    k_d   = k_q;
    q_d   = q_q;
    b_d   = b_q;
    r_d   = r_q;
    hi_d  = hi_q;
    err_d = err_q;
    if (ctrl_i.load) begin
      x_d   = a_m;
      y_d   = b_m;
      k_d   = '0;
      q_d   = a_m;
      b_d   = b_m;
      r_d   = '0;
      hi_d  = '0;
      err_d = status_o.op_zero;
    end else begin
      case (ctrl_i.phase)
        gcl_pkg::ST_GCD: begin
          if (y_q == '0) begin
            if (k_q != '0) begin
              x_d = {x_q[W-2:0], 1'b0};
              k_d = k_q - 1'b1;
            end
          end else if (!x_q[0] && !y_q[0]) begin
            x_d = {1'b0, x_q[W-1:1]};
            y_d = {1'b0, y_q[W-1:1]};
            k_d = k_q + 1'b1;
          end else if (!x_q[0]) begin
            x_d = {1'b0, x_q[W-1:1]};
          end else if (!y_q[0]) begin
            y_d = {1'b0, y_q[W-1:1]};
          end else if (add_s[W]) begin
            x_d = y_q;
            y_d = x_q;
          end else begin
            y_d = add_s[W-1:0];
          end
        end
        gcl_pkg::ST_DIV: begin
          r_d = add_s[W] ? part[W-1:0] : add_s[W-1:0];
          q_d = {q_q[W-2:0], ~add_s[W]};
        end
        gcl_pkg::ST_MUL: begin
          hi_d = add_s[W:1];
          q_d  = {add_s[0], q_q[W-1:1]};
        end
        default: begin
          x_d = x_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    k_q   <= k_d;
    q_q   <= q_d;
    b_q   <= b_d;
    r_q   <= r_d;
    hi_q  <= hi_d;
    err_q <= err_d;
  end

  assign status_o.op_zero  = (a_m == '0) || (b_m == '0);
  assign status_o.gcd_done = (y_q == '0) && (k_q == '0);
  assign gcd_o  = x_q;
  assign prod_o = {hi_q, q_q};
  assign err_o  = err_q;

endmodule

// File: src/gcl_ctrl.sv
module gcl_ctrl #(
  parameter int W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             out_free_i,
  input  gcl_pkg::status_t status_i,
  output gcl_pkg::ctrl_t   ctrl_o,
  output logic             busy_o,
  output logic             out_load_o
);

  localparam int CW = $clog2(W);

  gcl_pkg::state_e state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            cnt_last;

  assign cnt_last = (cnt_q == CW'(W - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      gcl_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.op_zero ? gcl_pkg::ST_OUT : gcl_pkg::ST_GCD;
        end
      end
      gcl_pkg::ST_GCD: begin
        if (status_i.gcd_done) begin
          state_d = gcl_pkg::ST_DIV;
        end
      end
      gcl_pkg::ST_DIV: begin
        if (cnt_last) begin
          state_d = gcl_pkg::ST_MUL;
        end
      end
      gcl_pkg::ST_MUL: begin
        if (cnt_last) begin
          state_d = gcl_pkg::ST_OUT;
        end
      end
      gcl_pkg::ST_OUT: begin
        if (out_free_i) begin
          state_d = gcl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = gcl_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cnt_d        = cnt_q;
    ctrl_o.phase = state_q;
    ctrl_o.load  = 1'b0;
    busy_o       = 1'b1;
    out_load_o   = 1'b0;
    case (state_q)
      gcl_pkg::ST_IDLE: begin
        busy_o      = 1'b0;
        ctrl_o.load = in_valid_i;
        cnt_d       = '0;
      end
      gcl_pkg::ST_DIV, gcl_pkg::ST_MUL: begin
        cnt_d = cnt_last ? '0 : cnt_q + 1'b1;
      end
      gcl_pkg::ST_OUT: begin
        out_load_o = out_free_i;
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gcl_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// File: src/gcd_lcm_unit.sv
// gcd_lcm_unit: greatest common divisor and least common multiple of two
// unsigned operands, of which the low OPERAND_WIDTH bits are used.
// Input channel: in_valid_i / in_stall_o with operand_a_i and operand_b_i.
// Output channel: out_valid_o / out_stall_i with divisor_out_o,
// multiple_out_o and error_flag_o. A transfer happens on a clock edge where
// valid is high and stall is low.
// One item at a time: in_stall_o stays high from the cycle after an item is
// taken until its result is moved into the output register. An item takes
// a binary gcd pass on the shared adder, then a restoring divide (a / gcd)
// and a shift-add multiply by b on the same adder, then a handoff state that
// moves the result into the output register.
// A zero operand skips all of that: the sequencer goes straight to the
// handoff, and the result (error flag, zero values) is moved into the
// output register as soon as that register is free.
// A finished result waits in the output register while out_stall_i is high;
// the next item is taken meanwhile and held at the end of its work until
// the register frees. Reset clears the sequencer and the output valid.
module gcd_lcm_unit #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] divisor_out_o,
  output logic [63:0] multiple_out_o,
  output logic        error_flag_o
);

  localparam int W = OPERAND_WIDTH;

  gcl_pkg::ctrl_t   ctrl;
  gcl_pkg::status_t status;
  logic             busy, out_load, out_free, err;
  logic [W-1:0]     gcd;
  logic [2*W-1:0]   prod;

  logic             out_valid_q, out_valid_d;
  logic [31:0]      div_q;
  logic [63:0]      mul_q;
  logic             err_q;

  gcl_ctrl #(
    .W (W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .status_i   (status),
    .ctrl_o     (ctrl),
    .busy_o     (busy),
    .out_load_o (out_load)
  );

  gcl_dp #(
    .W (W)
  ) u_dp (
    .clk_i       (clk_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .gcd_o       (gcd),
    .prod_o      (prod),
    .err_o       (err)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      div_q <= err ? '0 : 32'(gcd);
      mul_q <= err ? '0 : 64'(prod);
      err_q <= err;
    end
  end

  assign in_stall_o     = busy;
  assign out_valid_o    = out_valid_q;
  assign divisor_out_o  = div_q;
  assign multiple_out_o = mul_q;
  assign error_flag_o   = err_q;

endmodule

// File: tb/gcd_lcm_unit_tb.sv
`timescale 1ns / 100ps

module gcd_lcm_unit_tb;

  localparam int          OPW        = 32;
  localparam logic [31:0] OP_MASK    = 32'((64'd1 << OPW) - 64'd1);
  localparam int unsigned N_RANDOM   = 1580;
  localparam int unsigned PHASE1_AT  = 550;
  localparam int unsigned PHASE2_AT  = 1100;
  localparam int unsigned DRAIN      = 250;
  localparam int unsigned MAX_CYCLES = 1_500_000;

  typedef struct packed {
    logic [31:0] divisor;
    logic [63:0] multiple;
    logic        err;
  } gcd_lcm_t;

  typedef struct {
    logic [31:0] a;
    logic [31:0] b;
    bit          hold;
  } operand_pair_t;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic [31:0] op_a      = '0;
  logic [31:0] op_b      = '0;
  logic        out_stall = 1'b0;

  logic        in_stall;
  logic        out_valid;
  logic [31:0] divisor;
  logic [63:0] multiple;
  logic        err_flag;

  operand_pair_t pend_q[$];
  gcd_lcm_t      answer_q[$];
  gcd_lcm_t      want;
  int unsigned   n_sent = 0;
  int unsigned   n_got  = 0;
  int unsigned   n_err  = 0;
  int unsigned   cycles = 0;
  int unsigned   tx_idle;
  int unsigned   rx_idle;

  gcd_lcm_unit #(
    .OPERAND_WIDTH(OPW)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .operand_a_i   (op_a),
    .operand_b_i   (op_b),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .divisor_out_o (divisor),
    .multiple_out_o(multiple),
    .error_flag_o  (err_flag)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic gcd_lcm_t gcd_lcm_of(logic [31:0] a_raw, logic [31:0] b_raw);
    logic [31:0] a, b, x, y, r;
    gcd_lcm_t    res;
    a = a_raw & OP_MASK;
    b = b_raw & OP_MASK;
    if (a == '0 || b == '0) begin
      res.divisor  = '0;
      res.multiple = '0;
      res.err      = 1'b1;
    end else begin
      x = a;
      y = b;
      while (y != '0) begin
        r = x % y;
        x = y;
        y = r;
      end
      res.divisor  = x;
      res.multiple = 64'(a / x) * 64'(b);
      res.err      = 1'b0;
    end
    return res;
  endfunction

  task automatic add_pair(logic [31:0] a, logic [31:0] b, bit hold);
    operand_pair_t p;
    p.a    = a;
    p.b    = b;
    p.hold = hold;
    pend_q.push_back(p);
  endtask

  // idling per phase: sender light / receiver heavy, then swapped, then none
  always_comb begin
    if (n_sent < PHASE1_AT) begin
      tx_idle = 15;
      rx_idle = 88;
    end else if (n_sent < PHASE2_AT) begin
      tx_idle = 88;
      rx_idle = 15;
    end else begin
      tx_idle = 0;
      rx_idle = 0;
    end
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      op_a     <= '0;
      op_b     <= '0;
      n_sent   <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        answer_q.push_back(gcd_lcm_of(op_a, op_b));
        n_sent <= n_sent + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pend_q.size() != 0 &&
            !(pend_q[0].hold && (n_sent != n_got || (in_valid && !in_stall))) &&
            $urandom_range(99) >= tx_idle) begin
          in_valid <= 1'b1;
          op_a     <= pend_q[0].a;
          op_b     <= pend_q[0].b;
          pend_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle);
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_got <= 0;
    end else if (out_valid && !out_stall) begin
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected item div=%h mul=%h err=%b",
                 $time, divisor, multiple, err_flag);
        n_err++;
      end else begin
        want = answer_q.pop_front();
        n_got <= n_got + 1;
        if (divisor !== want.divisor) begin
          $display("%0t: divisor expected %h actual %h", $time, want.divisor, divisor);
          n_err++;
        end
        if (multiple !== want.multiple) begin
          $display("%0t: multiple expected %h actual %h", $time, want.multiple, multiple);
          n_err++;
        end
        if (err_flag !== want.err) begin
          $display("%0t: error flag expected %b actual %b", $time, want.err, err_flag);
          n_err++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == MAX_CYCLES) begin
      $display("%0t: timeout", $time);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int unsigned sel, wg, wx, wy;
    logic [31:0] g, x, y;

    // zero operands, ones, extremes, equal, coprime and common-factor pairs
    add_pair(32'h0000_0000, 32'h0000_0000, 1'b0);
    add_pair(32'h0000_0000, 32'h0000_0005, 1'b0);
    add_pair(32'h0000_0007, 32'h0000_0000, 1'b0);
    add_pair(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    add_pair(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    add_pair(32'h0000_0001, 32'h0000_0001, 1'b0);
    add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_pair(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
    add_pair(32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
    add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0);
    add_pair(32'hFFFF_FFFE, 32'h7FFF_FFFF, 1'b0);
    add_pair(32'hFFFF_FFFB, 32'hFFFF_FFEF, 1'b0);
    add_pair(32'h8000_0000, 32'h8000_0000, 1'b0);
    add_pair(32'h8000_0000, 32'h0000_0001, 1'b0);
    add_pair(32'h8000_0000, 32'h0000_0003, 1'b0);
    add_pair(32'h0000_000C, 32'h0000_0012, 1'b0);
    add_pair(32'h0000_0012, 32'h0000_000C, 1'b0);
    add_pair(32'h0000_000D, 32'h0000_000D, 1'b0);
    add_pair(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    add_pair(32'h0001_0000, 32'h0000_FFFF, 1'b0);
    add_pair(32'h0000_0006, 32'hFFFF_FFFF, 1'b0);

    for (int unsigned k = 0; k < N_RANDOM; k++) begin
      sel = $urandom_range(99);
      if (sel < 4) begin
        x = ($urandom_range(1)) ? $urandom : '0;
        y = (x == '0 && $urandom_range(1)) ? $urandom : '0;
        if ($urandom_range(1)) begin
          add_pair(x, y, k % 400 == 0);
        end else begin
          add_pair(y, x, k % 400 == 0);
        end
      end else if (sel < 10) begin
        x = $urandom >> $urandom_range(31);
        add_pair(x, x, k % 400 == 0);
      end else if (sel < 50) begin
        // shared factor g times two cofactors, product fits in 32 bits
        wg = $urandom_range(31, 1);
        wx = $urandom_range(32 - wg, 1);
        wy = $urandom_range(32 - wg, 1);
        g  = ($urandom >> (32 - wg)) | 32'd1;
        x  = $urandom >> (32 - wx);
        y  = $urandom >> (32 - wy);
        if (x == '0) x = 32'd1;
        if (y == '0) y = 32'd1;
        add_pair(g * x, g * y, k % 400 == 0);
      end else if (sel < 70) begin
        add_pair($urandom >> $urandom_range(31), $urandom >> $urandom_range(31),
                 k % 400 == 0);
      end else begin
        add_pair($urandom, $urandom, k % 400 == 0);
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pend_q.size() != 0 || in_valid || n_got != n_sent) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    if (answer_q.size() != 0) begin
      $display("%0t: %0d items never arrived", $time, answer_q.size());
      n_err++;
    end
    if (n_err == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
src/gcl_pkg.sv
src/gcl_dp.sv
src/gcl_ctrl.sv
src/gcd_lcm_unit.sv
tb/gcd_lcm_unit_tb.sv
